// File: hw/rtl/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
package tgc_pkg;

  // Fixed field widths
  localparam int COUNT_W = 4;
  localparam int TIME_W  = 32;
  localparam int SWIPE_W = 12;
  localparam int FLICK_W = 16;
  localparam int PINCH_W = 16;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;

  // Register reset values
  localparam logic [SWIPE_W-1:0] SWIPE_RST = 12'd80;
  localparam logic [FLICK_W-1:0] FLICK_RST = 16'd200;
  localparam logic [PINCH_W-1:0] PINCH_RST = 16'd8;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_SWIPE = 2'd0;
  localparam logic [1:0] REG_FLICK = 2'd1;
  localparam logic [1:0] REG_PINCH = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQL,
    ST_ROOT,
    ST_WAIT,
    ST_FIN
  } state_t;

  // Command to the shared square/accumulate unit
  typedef struct packed {
    logic en;
    logic load;
  } sq_cmd_t;

endpackage

// File: hw/rtl/tgc_sq_acc.sv
// Shared unit: squares an absolute difference and loads or accumulates it.
module tgc_sq_acc #(
  parameter int MUL_W = 12
) (
  input  logic               clk,
  input  tgc_pkg::sq_cmd_t   cmd,
  input  logic [MUL_W-1:0]   op_a,
  input  logic [MUL_W-1:0]   op_b,
  output logic [2*MUL_W:0]   acc
);
  import tgc_pkg::*;

  logic [MUL_W-1:0]   diff;
  logic [2*MUL_W-1:0] sq;
  logic [2*MUL_W:0]   acc_r;
  logic [2*MUL_W:0]   acc_nxt;

  // |a - b| squared
  always_comb begin
    diff = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
    sq   = diff * diff;
  end

  // load or add
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.en) begin
      if (cmd.load) begin
        acc_nxt = {1'b0, sq};
      end else begin
        acc_nxt = acc_r + {1'b0, sq};
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: hw/rtl/tgc_sqrt.sv
// Iterative floor square root, one root bit per cycle.
module tgc_sqrt #(
  parameter int ROOT_W = 17
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);
  import tgc_pkg::*;

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_r, rad_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [REM_W+1:0]    shifted;
  logic [REM_W+1:0]    trial;

  // trial subtract of (4*root + 1) from the shifted remainder
  always_comb begin
    shifted = {rem_r, rad_r[2*ROOT_W-1 -: 2]};
    trial   = shifted - {2'b00, root_r, 2'b01};
  end

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = rad_r << 2;
      if (!trial[REM_W+1]) begin
        rem_nxt  = trial[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted[REM_W-1:0];
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: hw/rtl/touch_gesture_classifier.sv
// Touch gesture classifier: tap, swipe, flick and pinch from touch frames.
//
// One touch frame per input word (finger count, two points, ms timestamp);
// one result word per frame (gesture flags, touching, tracked point, count).
// Both channels use valid/stall; a word moves when valid is high and stall
// is low. Registers sit on an APB-style port at byte addresses 0, 4, 8.
// A small sequencer drives one shared square/accumulate unit and an
// iterative square root, so in_stall stays high while a frame is worked on.
// Steps from acceptance to the result register, by kind of frame:
//   no release and fewer than two fingers: straight to the commit step
//   release (classification): square dx, add dy^2, then square the swipe
//     distance while keeping the travel, then commit
//   two or more fingers (spread): square dx, add dy^2, start the root unit
//     and wait for it (it resolves one root bit per cycle), then commit.
// A finished result sits in the output register; the next frame is worked
// on meanwhile and waits in its last step only if that register is still
// held by out_stall. Reset (rst_n low, synchronous) ends any touch, clears
// the tracked points and pinch reference and restores register defaults.
module touch_gesture_classifier #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tgc_pkg::COUNT_W-1:0]    in_finger_count,
  input  logic [COORD_BITS-1:0]          in_first_x,
  input  logic [COORD_BITS-1:0]          in_first_y,
  input  logic [COORD_BITS-1:0]          in_second_x,
  input  logic [COORD_BITS-1:0]          in_second_y,
  input  logic [tgc_pkg::TIME_W-1:0]     in_now_ms,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_tap,
  output logic                           out_swipe,
  output logic                           out_flick,
  output logic                           out_pinch_in,
  output logic                           out_pinch_out,
  output logic                           out_touching,
  output logic [COORD_BITS-1:0]          out_current_x,
  output logic [COORD_BITS-1:0]          out_current_y,
  output logic [tgc_pkg::COUNT_W-1:0]    out_fingers,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tgc_pkg::ADDR_W-1:0]     paddr,
  input  logic [tgc_pkg::DATA_W-1:0]     pwdata,
  output logic [tgc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);
  import tgc_pkg::*;

  localparam int MUL_W    = (COORD_BITS > SWIPE_W) ? COORD_BITS : SWIPE_W;
  localparam int ACC_W    = 2 * MUL_W + 1;
  localparam int TRAV_W   = 2 * COORD_BITS + 1;
  localparam int SPREAD_W = COORD_BITS + FRAC_BITS + 1;
  localparam int RAD_W    = 2 * SPREAD_W;
  localparam int DIFF_W   = (SPREAD_W > PINCH_W) ? SPREAD_W : PINCH_W;

  // configuration registers
  logic [SWIPE_W-1:0] swipe_dist_r;
  logic [FLICK_W-1:0] flick_time_r;
  logic [PINCH_W-1:0] pinch_thr_r;
  logic               cfg_wr;

  // sequencer
  state_t state_r, state_nxt;
  logic   accept;
  logic   out_free;
  logic   release_r;

  // latched frame
  logic [COUNT_W-1:0]    cnt_r;
  logic [COORD_BITS-1:0] ax_r, ay_r, bx_r, by_r;
  logic [TIME_W-1:0]     now_r;

  // tracking state
  logic                  in_touch_r;
  logic [COORD_BITS-1:0] start_px_r, start_py_r, last_px_r, last_py_r;
  logic [TIME_W-1:0]     start_ms_r;
  logic [SPREAD_W-1:0]   prior_r;
  logic [TRAV_W-1:0]     trav_r;

  // shared units
  sq_cmd_t             sq_cmd;
  logic [MUL_W-1:0]    op_a, op_b;
  logic [ACC_W-1:0]    acc;
  logic                root_start;
  logic                root_done;
  logic [SPREAD_W-1:0] spread;
  logic [RAD_W-1:0]    radicand;

  // result register
  logic                  out_valid_r;
  logic                  tap_r, swipe_r, flick_r, pin_r, pout_r, touching_r;
  logic [COORD_BITS-1:0] cur_x_r, cur_y_r;
  logic [COUNT_W-1:0]    fingers_r;

  // commit values
  logic                  commit;
  logic                  is_tap, is_swipe, is_flick, is_pin, is_pout;
  logic                  multi;
  logic                  grew;
  logic [SPREAD_W-1:0]   sdiff;
  logic [TIME_W-1:0]     elapsed;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign multi    = cnt_r > COUNT_W'(1);

  //--------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swipe_dist_r <= SWIPE_RST;
      flick_time_r <= FLICK_RST;
      pinch_thr_r  <= PINCH_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SWIPE: swipe_dist_r <= pwdata[SWIPE_W-1:0];
        REG_FLICK: flick_time_r <= pwdata[FLICK_W-1:0];
        REG_PINCH: pinch_thr_r  <= pwdata[PINCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SWIPE: prdata = DATA_W'(swipe_dist_r);
      REG_FLICK: prdata = DATA_W'(flick_time_r);
      REG_PINCH: prdata = DATA_W'(pinch_thr_r);
      default:   prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------
  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((in_finger_count == '0 && in_touch_r) || in_finger_count > COUNT_W'(1)) begin
            state_nxt = ST_SQX;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = release_r ? ST_SQL : ST_ROOT;
      ST_SQL:  state_nxt = ST_FIN;
      ST_ROOT: state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = root_done ? ST_FIN : ST_WAIT;
      ST_FIN:  state_nxt = out_free ? ST_IDLE : ST_FIN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall   = 1'b1;
    sq_cmd     = '0;
    root_start = 1'b0;
    commit     = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_SQX:  sq_cmd   = '{en: 1'b1, load: 1'b1};
      ST_SQY:  sq_cmd   = '{en: 1'b1, load: 1'b0};
      ST_SQL:  sq_cmd   = '{en: 1'b1, load: 1'b1};
      ST_ROOT: root_start = 1'b1;
      ST_WAIT: ;
      ST_FIN:  commit   = out_free;
      default: ;
    endcase
  end

  // operand selection for the shared unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_SQX: begin
        op_a = release_r ? MUL_W'(last_px_r) : MUL_W'(ax_r);
        op_b = release_r ? MUL_W'(start_px_r) : MUL_W'(bx_r);
      end
      ST_SQY: begin
        op_a = release_r ? MUL_W'(last_py_r) : MUL_W'(ay_r);
        op_b = release_r ? MUL_W'(start_py_r) : MUL_W'(by_r);
      end
      ST_SQL: op_a = MUL_W'(swipe_dist_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r     <= in_finger_count;
      ax_r      <= in_first_x;
      ay_r      <= in_first_y;
      bx_r      <= in_second_x;
      by_r      <= in_second_y;
      now_r     <= in_now_ms;
      release_r <= (in_finger_count == '0) && in_touch_r;
    end
    // keep the travel while the unit squares the swipe distance
    if (state_r == ST_SQL) begin
      trav_r <= acc[TRAV_W-1:0];
    end
  end

  //--------------------------------------------------------------------
  // shared arithmetic
  tgc_sq_acc #(
    .MUL_W (MUL_W)
  ) u_sq_acc (
    .clk  (clk),
    .cmd  (sq_cmd),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // squared spread scaled to FRAC_BITS fraction bits
  assign radicand = RAD_W'(acc[TRAV_W-1:0]) << (2 * FRAC_BITS);

  tgc_sqrt #(
    .ROOT_W (SPREAD_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (spread)
  );

  //--------------------------------------------------------------------
  // classification
  always_comb begin
    elapsed  = now_r - start_ms_r;
    is_tap   = release_r && (ACC_W'(trav_r) < acc);
    is_swipe = release_r && !(ACC_W'(trav_r) < acc);
    is_flick = is_swipe && (elapsed <= TIME_W'(flick_time_r));
    grew     = spread > prior_r;
    sdiff    = grew ? (spread - prior_r) : (prior_r - spread);
    is_pout  = multi && (prior_r != '0) && grew &&
               (DIFF_W'(sdiff) > DIFF_W'(pinch_thr_r));
    is_pin   = multi && (prior_r != '0) && !grew &&
               (DIFF_W'(sdiff) > DIFF_W'(pinch_thr_r));
  end

  // tracking state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_touch_r <= 1'b0;
      start_px_r <= '0;
      start_py_r <= '0;
      last_px_r  <= '0;
      last_py_r  <= '0;
      start_ms_r <= '0;
      prior_r    <= '0;
    end else if (commit) begin
      if (cnt_r != '0) begin
        if (!in_touch_r) begin
          start_px_r <= ax_r;
          start_py_r <= ay_r;
          start_ms_r <= now_r;
        end
        in_touch_r <= 1'b1;
        last_px_r  <= ax_r;
        last_py_r  <= ay_r;
        if (multi) begin
          prior_r <= spread;
        end
      end else if (release_r) begin
        in_touch_r <= 1'b0;
        prior_r    <= '0;
      end
    end
  end

  //--------------------------------------------------------------------
  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      tap_r      <= is_tap;
      swipe_r    <= is_swipe;
      flick_r    <= is_flick;
      pin_r      <= is_pin;
      pout_r     <= is_pout;
      touching_r <= cnt_r != '0;
      cur_x_r    <= (cnt_r != '0) ? ax_r : last_px_r;
      cur_y_r    <= (cnt_r != '0) ? ay_r : last_py_r;
      fingers_r  <= cnt_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tap       = tap_r;
  assign out_swipe     = swipe_r;
  assign out_flick     = flick_r;
  assign out_pinch_in  = pin_r;
  assign out_pinch_out = pout_r;
  assign out_touching  = touching_r;
  assign out_current_x = cur_x_r;
  assign out_current_y = cur_y_r;
  assign out_fingers   = fingers_r;

endmodule

// File: hw/rtl/tgc_checker.sv
// Port-level checks for the touch gesture classifier, bound to the top level.
module tgc_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_tap,
  input logic                        out_swipe,
  input logic                        out_flick,
  input logic                        out_touching,
  input logic [COORD_BITS-1:0]       out_current_x,
  input logic [tgc_pkg::COUNT_W-1:0] out_fingers
);
  import tgc_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_x) &&
                               $stable(out_fingers) && $stable(out_tap))
    else $error("stalled result word changed");

  // one frame at a time: busy right after an accepted word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a frame is in progress");

  // a release is either a tap or a swipe
  a_tap_swipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_tap && out_swipe))
    else $error("tap and swipe both set");

  // a flick is always a swipe
  a_flick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_flick |-> out_swipe)
    else $error("flick without swipe");

  // a classified release ends the touch with no fingers down
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tap || out_swipe) |-> !out_touching && (out_fingers == '0))
    else $error("release classified while touching");

endmodule

bind touch_gesture_classifier tgc_checker #(
  .COORD_BITS (COORD_BITS)
) u_tgc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tap       (out_tap),
  .out_swipe     (out_swipe),
  .out_flick     (out_flick),
  .out_touching  (out_touching),
  .out_current_x (out_current_x),
  .out_fingers   (out_fingers)
);
